### rtl/cor_pkg.sv
// Shared types, constants and the octant point function of the circle rasterizer.
package cor_pkg;

   localparam int MAX_SURFACE_SIDE = 4096;

   localparam int COORD_W    = 13;
   localparam int RADIUS_W   = 12;
   localparam int COLOR_W    = 32;
   localparam int PIXEL_W    = 14;
   localparam int ADDR_W     = 24;
   localparam int DECISION_W = 18;
   localparam int SIDE_W     = 13;

   localparam int QUEUE_DEPTH     = 2;
   localparam int POINTS_PER_STEP = 8;
   localparam int POINT_IDX_W     = $clog2(POINTS_PER_STEP);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   localparam int  CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURFACE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SURFACE_HEIGHT = 1'b1;

   // One step command handed from the front to the back through the queue.
   typedef struct packed {
      logic                      blank;
      logic                      done;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [COLOR_W-1:0]        color;
   } cmd_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] px;
      logic signed [PIXEL_W-1:0] py;
   } point_type;

   // Returns the k-th of the eight symmetric points of a step.
   function automatic point_type octant_point(cmd_type c, logic [POINT_IDX_W-1:0] k);
      logic signed [PIXEL_W-1:0] cx;
      logic signed [PIXEL_W-1:0] cy;
      logic signed [PIXEL_W-1:0] x;
      logic signed [PIXEL_W-1:0] y;
      point_type p;
      cx = {c.cx[COORD_W-1], c.cx};
      cy = {c.cy[COORD_W-1], c.cy};
      x  = {c.x[COORD_W-1], c.x};
      y  = {c.y[COORD_W-1], c.y};
      case (k)
         3'd0: begin p.px = cx + x; p.py = cy + y; end
         3'd1: begin p.px = cx + y; p.py = cy + x; end
         3'd2: begin p.px = cx - x; p.py = cy + y; end
         3'd3: begin p.px = cx - y; p.py = cy + x; end
         3'd4: begin p.px = cx + x; p.py = cy - y; end
         3'd5: begin p.px = cx + y; p.py = cy - x; end
         3'd6: begin p.px = cx - x; p.py = cy - y; end
         3'd7: begin p.px = cx - y; p.py = cy - x; end
         default: begin p.px = cx; p.py = cy; end
      endcase
      return p;
   endfunction

endpackage

### rtl/cor_req_if.sv
// Request channel: valid, ready and the start or step word.
interface cor_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic signed [cor_pkg::COORD_W-1:0] center_x;
   logic signed [cor_pkg::COORD_W-1:0] center_y;
   logic [cor_pkg::RADIUS_W-1:0]       radius;
   logic [cor_pkg::COLOR_W-1:0]        color;

   modport source (output valid, mode, center_x, center_y, radius, color, input ready);
   modport sink   (input valid, mode, center_x, center_y, radius, color, output ready);
endinterface

### rtl/cor_rsp_if.sv
// Response channel: valid, ready and one pixel word.
interface cor_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cor_pkg::PIXEL_W-1:0] pixel_x;
   logic signed [cor_pkg::PIXEL_W-1:0] pixel_y;
   logic [cor_pkg::ADDR_W-1:0]         pixel_address;
   logic [cor_pkg::COLOR_W-1:0]        pixel_color;
   logic                               write_enable;
   logic                               last;
   logic                               done_res;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   write_enable, last, done_res, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   write_enable, last, done_res, output ready);
endinterface

### rtl/cor_front.sv
// Front end: accepts start and step words, runs the midpoint recurrence, queues step commands.
module cor_front (
   input  logic             clock,
   input  logic             reset,
   cor_req_if.sink          req_ch,
   output logic             push_valid,
   input  logic             push_ready,
   output cor_pkg::cmd_type push_data
);

   localparam int CW = cor_pkg::COORD_W;
   localparam int DW = cor_pkg::DECISION_W;

   logic                         active_ff, active_in;
   logic signed [CW-1:0]         cx_ff, cx_in;
   logic signed [CW-1:0]         cy_ff, cy_in;
   logic signed [CW-1:0]         x_ff, x_in;
   logic signed [CW-1:0]         y_ff, y_in;
   logic signed [DW-1:0]         d_ff, d_in;
   logic [cor_pkg::COLOR_W-1:0]  color_ff, color_in;

   logic                 accept;
   logic signed [DW-1:0] x_ext;
   logic signed [DW-1:0] y_ext;
   logic signed [CW-1:0] x_next;
   logic signed [CW-1:0] y_next;
   logic signed [DW-1:0] d_next;
   logic                 done_next;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;

   always_comb begin
      x_ext  = {{(DW-CW){x_ff[CW-1]}}, x_ff};
      y_ext  = {{(DW-CW){y_ff[CW-1]}}, y_ff};
      x_next = x_ff + CW'(1);
      if (d_ff[DW-1]) begin
         d_next = d_ff + (x_ext <<< 2) + DW'(6);
         y_next = y_ff;
      end else begin
         d_next = d_ff + ((x_ext - y_ext) <<< 2) + DW'(10);
         y_next = y_ff - CW'(1);
      end
      done_next = y_next < x_next;
   end

   always_comb begin
      active_in = active_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      color_in  = color_ff;

      push_valid      = accept && (req_ch.mode == cor_pkg::MODE_STEP);
      push_data.blank = !active_ff;
      push_data.done  = active_ff ? done_next : 1'b1;
      push_data.cx    = cx_ff;
      push_data.cy    = cy_ff;
      push_data.x     = x_ff;
      push_data.y     = y_ff;
      push_data.color = color_ff;

      if (accept) begin
         if (req_ch.mode == cor_pkg::MODE_START) begin
            active_in = 1'b1;
            cx_in     = req_ch.center_x;
            cy_in     = req_ch.center_y;
            x_in      = '0;
            y_in      = {1'b0, req_ch.radius};
            d_in      = DW'(3) - $signed({{(DW-cor_pkg::RADIUS_W-1){1'b0}},
                                          req_ch.radius, 1'b0});
            color_in  = req_ch.color;
         end else if (active_ff) begin
            x_in      = x_next;
            y_in      = y_next;
            d_in      = d_next;
            active_in = !done_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         d_ff      <= '0;
         color_ff  <= '0;
      end else begin
         active_ff <= active_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         d_ff      <= d_in;
         color_ff  <= color_in;
      end
   end

endmodule

### rtl/cor_queue.sv
// Short command queue between the front end and the pixel back end.
module cor_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cor_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cor_pkg::cmd_type pop_data
);

   localparam int DEPTH = cor_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cor_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/cor_back.sv
// Back end: a command yields eight clipped, addressed pixel words, one if blank.
module cor_back #(
   parameter int MAX_SIDE = cor_pkg::MAX_SURFACE_SIDE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  cor_pkg::cmd_type             pop_data,
   input  logic [cor_pkg::SIDE_W-1:0]   surface_width,
   input  logic [cor_pkg::SIDE_W-1:0]   surface_height,
   cor_rsp_if.source                    rsp_ch
);

   localparam int KW = cor_pkg::POINT_IDX_W;
   localparam int SW = cor_pkg::SIDE_W;
   localparam int PW = cor_pkg::PIXEL_W;
   localparam int AW = cor_pkg::ADDR_W;

   // Command stage: holds the command being expanded and the point index.
   logic                 a_valid_ff, a_valid_in;
   cor_pkg::cmd_type     a_cmd_ff, a_cmd_in;
   logic [KW-1:0]        k_ff, k_in;

   // Point stage.
   logic                 b_valid_ff, b_valid_in;
   cor_pkg::point_type   b_point_ff;
   logic                 b_blank_ff, b_last_ff, b_done_ff;
   logic [cor_pkg::COLOR_W-1:0] b_color_ff;

   // Output register.
   logic                 o_valid_ff, o_valid_in;
   logic signed [PW-1:0] o_x_ff, o_y_ff;
   logic [AW-1:0]        o_addr_ff;
   logic [cor_pkg::COLOR_W-1:0] o_color_ff;
   logic                 o_we_ff, o_last_ff, o_done_ff;

   logic                 o_free, b_free, a_issue, a_last;
   cor_pkg::point_type   a_point;
   logic [SW-1:0]        w_eff, h_eff;
   logic                 on_surface;
   logic [2*SW-1:0]      addr_sum;

   assign o_free  = !o_valid_ff || rsp_ch.ready;
   assign b_free  = !b_valid_ff || o_free;
   assign a_issue = a_valid_ff && b_free;
   assign a_last  = a_cmd_ff.blank || (k_ff == KW'(cor_pkg::POINTS_PER_STEP - 1));
   assign pop_ready = !a_valid_ff || (a_issue && a_last);
   assign a_point = cor_pkg::octant_point(a_cmd_ff, k_ff);

   always_comb begin
      a_valid_in = a_valid_ff;
      a_cmd_in   = a_cmd_ff;
      k_in       = k_ff;
      if (pop_ready) begin
         a_valid_in = pop_valid;
         a_cmd_in   = pop_data;
         k_in       = '0;
      end else if (a_issue) begin
         k_in = k_ff + KW'(1);
      end
      b_valid_in = b_free ? a_issue : b_valid_ff;
      o_valid_in = o_free ? b_valid_ff : o_valid_ff;
   end

   // Clipping and row-major addressing of the point stage.
   always_comb begin
      w_eff = (int'(surface_width) > MAX_SIDE) ? SW'(MAX_SIDE) : surface_width;
      h_eff = (int'(surface_height) > MAX_SIDE) ? SW'(MAX_SIDE) : surface_height;
      on_surface = !b_blank_ff && !b_point_ff.px[PW-1] && !b_point_ff.py[PW-1]
               && (b_point_ff.px[SW-1:0] < w_eff) && (b_point_ff.py[SW-1:0] < h_eff);
      addr_sum = b_point_ff.py[SW-1:0] * w_eff + {{SW{1'b0}}, b_point_ff.px[SW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         k_ff       <= '0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         k_ff       <= k_in;
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_cmd_ff <= a_cmd_in;
      if (a_issue) begin
         b_blank_ff <= a_cmd_ff.blank;
         b_last_ff  <= a_last;
         b_done_ff  <= a_cmd_ff.done;
         if (a_cmd_ff.blank) begin
            b_point_ff <= '0;
            b_color_ff <= '0;
         end else begin
            b_point_ff <= a_point;
            b_color_ff <= a_cmd_ff.color;
         end
      end
      if (b_valid_ff && o_free) begin
         o_x_ff     <= b_point_ff.px;
         o_y_ff     <= b_point_ff.py;
         o_addr_ff  <= on_surface ? addr_sum[AW-1:0] : '0;
         o_color_ff <= b_color_ff;
         o_we_ff    <= on_surface;
         o_last_ff  <= b_last_ff;
         o_done_ff  <= b_done_ff;
      end
   end

   assign rsp_ch.valid         = o_valid_ff;
   assign rsp_ch.pixel_x       = o_x_ff;
   assign rsp_ch.pixel_y       = o_y_ff;
   assign rsp_ch.pixel_address = o_addr_ff;
   assign rsp_ch.pixel_color   = o_color_ff;
   assign rsp_ch.write_enable  = o_we_ff;
   assign rsp_ch.last          = o_last_ff;
   assign rsp_ch.done_res      = o_done_ff;

endmodule

### rtl/circle_outline_rasterizer_core.sv
// Top level of the midpoint circle outline rasterizer.
//
// The request channel carries start words (mode 0: center, radius, color) and
// step words (mode 1). A start word loads a new circle and produces nothing.
// Each step word of an active circle produces eight pixel words on the response
// channel, one per octant, the eighth marked with last; every word of the step
// that completes the circle carries done_res. A step with no active circle
// produces a single blank word with last and done_res set.
// Each pixel word carries its coordinates, the row-major address y*width+x and
// a write enable that is set only when the point lies inside the surface.
// Surface width and height are written through the csr port while the block is
// idle; values above MAX_SURFACE_SIDE are clamped to it.
// A step word passes the command queue, the command and point stages and the
// output register before its first pixel word appears. Throughput: the
// response channel moves one word per cycle while the receiver is ready, paced
// by the point expansion in the back end. The front end runs ahead through
// a two-entry command queue, so it keeps taking words while the back end works.
// Reset clears the active circle, the queue and all valid flags, and loads the
// surface size of 640 by 480. When the receiver stalls, the output word holds
// and the stall backs up through the queue to the request ready.
module circle_outline_rasterizer_core #(
   parameter int MAX_SURFACE_SIDE = cor_pkg::MAX_SURFACE_SIDE
) (
   input  logic                              clock,
   input  logic                              reset,
   cor_req_if.sink                           req_ch,
   cor_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [cor_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cor_pkg::SIDE_W-1:0]        csr_write_data
);

   localparam int SW = cor_pkg::SIDE_W;

   logic [SW-1:0]     width_ff, width_in;
   logic [SW-1:0]     height_ff, height_in;

   logic              push_valid, push_ready;
   cor_pkg::cmd_type  push_data;
   logic              pop_valid, pop_ready;
   cor_pkg::cmd_type  pop_data;

   // Registers: the user writes only while the block is idle; not enforced.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            cor_pkg::CSR_SURFACE_WIDTH:  width_in  = csr_write_data;
            cor_pkg::CSR_SURFACE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(640);
         height_ff <= SW'(480);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Front end: midpoint recurrence and command generation.
   cor_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Command queue decouples the recurrence from pixel output.
   cor_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back end: octant expansion, clipping, addressing and the output register.
   cor_back #(
      .MAX_SIDE (MAX_SURFACE_SIDE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .surface_width  (width_ff),
      .surface_height (height_ff),
      .rsp_ch         (rsp_ch)
   );

endmodule

### rtl/cor_checker.sv
// Port-level checker for the circle rasterizer and its bind to the top level.
module cor_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [cor_pkg::PIXEL_W-1:0] pixel_x,
   input logic signed [cor_pkg::PIXEL_W-1:0] pixel_y,
   input logic [cor_pkg::ADDR_W-1:0]         pixel_address,
   input logic                               write_enable,
   input logic                               last,
   input logic                               done_res
);

   // A word that is held off must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // Clipped points never carry an address.
   a_clip_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !write_enable |-> pixel_address == '0)
      else $error("address on a clipped point");

   // A written point has nonnegative coordinates.
   a_we_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && write_enable |-> !pixel_x[cor_pkg::PIXEL_W-1]
                                    && !pixel_y[cor_pkg::PIXEL_W-1])
      else $error("write enable on a negative coordinate");

   // A done last word directly after a taken last word without done_res never has an address without a write.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last && !done_res |=> !(rsp_valid && done_res && last
                                    && pixel_address != '0 && !write_enable))
      else $error("done word with address but no write");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind circle_outline_rasterizer_core cor_checker u_cor_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .pixel_x       (rsp_ch.pixel_x),
   .pixel_y       (rsp_ch.pixel_y),
   .pixel_address (rsp_ch.pixel_address),
   .write_enable  (rsp_ch.write_enable),
   .last          (rsp_ch.last),
   .done_res      (rsp_ch.done_res)
);

### tb/sv/circle_outline_rasterizer_core_test.sv
// Self-checking testbench for the midpoint circle outline rasterizer core.
module circle_outline_rasterizer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Surface size that the block loads at reset.
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   // The cycle limit stays well above the slowest correct run here, even
   // with every pixel word waiting out a long receiver stall.
   localparam int CYCLE_LIMIT  = 400000;
   // Quiet cycles after the last pixel word before registers change or the
   // run ends.
   localparam int SETTLE_CYCLES = 8;

   // One request word as the sender drives it.
   typedef struct packed {
      logic                               mode;
      logic signed [cor_pkg::COORD_W-1:0] center_x;
      logic signed [cor_pkg::COORD_W-1:0] center_y;
      logic [cor_pkg::RADIUS_W-1:0]       radius;
      logic [cor_pkg::COLOR_W-1:0]        color;
   } circle_word_type;

   // One pixel word as the block returns it.
   typedef struct packed {
      logic signed [cor_pkg::PIXEL_W-1:0] px;
      logic signed [cor_pkg::PIXEL_W-1:0] py;
      logic [cor_pkg::ADDR_W-1:0]         addr;
      logic [cor_pkg::COLOR_W-1:0]        color;
      logic                               we;
      logic                               last;
      logic                               done;
   } pixel_word_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [cor_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cor_pkg::SIDE_W-1:0]      csr_write_data;

   cor_req_if req_ch ();
   cor_rsp_if rsp_ch ();

   circle_outline_rasterizer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Words waiting to be offered, the word on the request channel now, and
   // the pixel words the block still owes us, oldest first.
   circle_word_type pending_words[$];
   circle_word_type cur_word;
   pixel_word_type  due_pixels[$];

   // Words queued but not yet taken by the block; kept apart from the queue so
   // the drain wait never races with the driver popping a word.
   int words_in_flight = 0;
   int failures = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic word_taken = 1'b0;

   // Our own copy of the rasterizer state and of the surface registers.
   logic signed [cor_pkg::COORD_W-1:0]    circ_cx;
   logic signed [cor_pkg::COORD_W-1:0]    circ_cy;
   int                                    circ_x;
   int                                    circ_y;
   logic signed [cor_pkg::DECISION_W-1:0] circ_d;
   logic [cor_pkg::COLOR_W-1:0]           circ_color;
   logic                                  circ_active;
   int                                    surf_width;
   int                                    surf_height;

   always #1 clock = ~clock;

   // Works out the pixel words that one accepted request word must produce
   // and appends them to due_pixels, advancing the circle state as it goes.
   function automatic void trace_octants(circle_word_type wd);
      int cx;
      int cy;
      int dd;
      int w_eff;
      int h_eff;
      int px;
      int py;
      int addr;
      int ox[8];
      int oy[8];
      logic done;
      pixel_word_type pw;
      if (wd.mode == cor_pkg::MODE_START) begin
         // A start word loads a new circle, replacing any circle in progress.
         circ_cx     = wd.center_x;
         circ_cy     = wd.center_y;
         circ_x      = 0;
         circ_y      = wd.radius;
         dd          = 3 - 2 * circ_y;
         circ_d      = dd[cor_pkg::DECISION_W-1:0];
         circ_color  = wd.color;
         circ_active = 1'b1;
         return;
      end
      if (!circ_active) begin
         // A step with nothing to draw gets a single blank word that closes itself.
         pw = '0;
         pw.last = 1'b1;
         pw.done = 1'b1;
         due_pixels.push_back(pw);
         return;
      end
      // The eight symmetric offsets use x and y as they stood before the step.
      ox = '{circ_x, circ_y, -circ_x, -circ_y, circ_x, circ_y, -circ_x, -circ_y};
      oy = '{circ_y, circ_x, circ_y, circ_x, -circ_y, -circ_x, -circ_y, -circ_x};
      cx = circ_cx;
      cy = circ_cy;
      dd = circ_d;
      if (dd < 0) begin
         dd = dd + 4 * circ_x + 6;
      end else begin
         dd = dd + 4 * (circ_x - circ_y) + 10;
         circ_y = circ_y - 1;
      end
      circ_x = circ_x + 1;
      circ_d = dd[cor_pkg::DECISION_W-1:0];
      done = (circ_y < circ_x);
      if (done) begin
         circ_active = 1'b0;
      end
      // Register values above the largest surface side saturate there.
      w_eff = (surf_width > cor_pkg::MAX_SURFACE_SIDE) ? cor_pkg::MAX_SURFACE_SIDE
                                                       : surf_width;
      h_eff = (surf_height > cor_pkg::MAX_SURFACE_SIDE) ? cor_pkg::MAX_SURFACE_SIDE
                                                        : surf_height;
      for (int k = 0; k < cor_pkg::POINTS_PER_STEP; k++) begin
         px = cx + ox[k];
         py = cy + oy[k];
         pw.px    = px[cor_pkg::PIXEL_W-1:0];
         pw.py    = py[cor_pkg::PIXEL_W-1:0];
         pw.color = circ_color;
         pw.we    = (px >= 0 && py >= 0 && px < w_eff && py < h_eff);
         // Points off the surface carry a zero address.
         addr     = pw.we ? py * w_eff + px : 0;
         pw.addr  = addr[cor_pkg::ADDR_W-1:0];
         pw.last  = (k == cor_pkg::POINTS_PER_STEP - 1);
         pw.done  = done;
         due_pixels.push_back(pw);
      end
   endfunction

   function automatic circle_word_type make_start(int cx, int cy, int r,
                                                  logic [cor_pkg::COLOR_W-1:0] color);
      circle_word_type wd;
      wd.mode     = cor_pkg::MODE_START;
      wd.center_x = cx[cor_pkg::COORD_W-1:0];
      wd.center_y = cy[cor_pkg::COORD_W-1:0];
      wd.radius   = r[cor_pkg::RADIUS_W-1:0];
      wd.color    = color;
      return wd;
   endfunction

   // Step words carry random payload, which the block must ignore.
   function automatic circle_word_type make_step();
      circle_word_type wd;
      wd = make_start($urandom, $urandom, $urandom, $urandom);
      wd.mode = cor_pkg::MODE_STEP;
      return wd;
   endfunction

   task automatic push_word(circle_word_type wd);
      pending_words.push_back(wd);
      words_in_flight++;
   endtask

   // Waits until every queued word has been taken and every pixel word it
   // caused has come back, then lets the pipeline settle.
   task automatic wait_idle();
      while (words_in_flight != 0 || due_pixels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [cor_pkg::CSR_INDEX_W-1:0] idx, int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[cor_pkg::SIDE_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Sets a surface size and an idling mix once the block is idle, then
   // queues about budget words: mostly a start followed by a run of steps,
   // which may stop short of the end or run past it, and now and then a stray
   // step on its own.
   task automatic run_phase(int w, int h, int send_pct, int stall_pct, int budget);
      int left;
      int span_w;
      int span_h;
      int cx;
      int cy;
      int r;
      int n;
      wait_idle();
      write_reg(cor_pkg::CSR_SURFACE_WIDTH, w);
      write_reg(cor_pkg::CSR_SURFACE_HEIGHT, h);
      sender_idle_pct = send_pct;
      rsp_stall_pct   = stall_pct;
      span_w = (w > 4000) ? 4000 : w;
      span_h = (h > 4000) ? 4000 : h;
      left = budget;
      while (left > 0) begin
         if ($urandom_range(7) == 0) begin
            push_word(make_step());
            left--;
         end else begin
            // Most centers sit on or just around the surface so that both
            // clipped and written points show up; some go anywhere.
            if ($urandom_range(5) == 0) begin
               cx = $urandom;
               cy = $urandom;
            end else begin
               cx = int'($urandom_range(0, span_w + 4)) - 2;
               cy = int'($urandom_range(0, span_h + 4)) - 2;
            end
            // Small radii complete in a handful of steps; a large one now and
            // then exercises the wide coordinate range.
            r = ($urandom_range(7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
            n = $urandom_range(1, r * 3 / 4 + 3);
            if (n > 14) begin
               n = 14;
            end
            push_word(make_start(cx, cy, r, $urandom));
            repeat (n) push_word(make_step());
            left -= n + 1;
         end
      end
   endtask

   // Driver: offers the next pending word at the falling edge unless the
   // sender idles, and holds a word until the block takes it. The receiver
   // ready is rerolled every cycle.
   always @(negedge clock) begin : feed_words
      logic keep_word;
      keep_word = req_ch.valid && !word_taken;
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!keep_word) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               cur_word = pending_words.pop_front();
               req_ch.mode     <= cur_word.mode;
               req_ch.center_x <= cur_word.center_x;
               req_ch.center_y <= cur_word.center_y;
               req_ch.radius   <= cur_word.radius;
               req_ch.color    <= cur_word.color;
               req_ch.valid    <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: at the rising edge it follows register writes, predicts for
   // every word the block takes, and checks every pixel word it hands out.
   always @(posedge clock) begin : watch_ports
      pixel_word_type got;
      pixel_word_type want;
      if (reset) begin
         circ_cx     = '0;
         circ_cy     = '0;
         circ_x      = 0;
         circ_y      = 0;
         circ_d      = '0;
         circ_color  = '0;
         circ_active = 1'b0;
         surf_width  = RESET_WIDTH;
         surf_height = RESET_HEIGHT;
         word_taken  = 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               cor_pkg::CSR_SURFACE_WIDTH:  surf_width  = csr_write_data;
               cor_pkg::CSR_SURFACE_HEIGHT: surf_height = csr_write_data;
               default: ;
            endcase
         end
         word_taken = req_ch.valid && req_ch.ready;
         if (word_taken) begin
            trace_octants(cur_word);
            words_in_flight--;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.px    = rsp_ch.pixel_x;
            got.py    = rsp_ch.pixel_y;
            got.addr  = rsp_ch.pixel_address;
            got.color = rsp_ch.pixel_color;
            got.we    = rsp_ch.write_enable;
            got.last  = rsp_ch.last;
            got.done  = rsp_ch.done_res;
            if (due_pixels.size() == 0) begin
               $display("%0t: pixel word with none expected: x=%0d y=%0d addr=%h color=%h",
                        $time, got.px, got.py, got.addr, got.color);
               failures++;
            end else begin
               want = due_pixels.pop_front();
               if (got !== want) begin
                  $display("%0t: pixel word mismatch", $time);
                  $display("   expected x=%0d y=%0d addr=%h color=%h we=%b last=%b done=%b",
                           want.px, want.py, want.addr, want.color, want.we, want.last,
                           want.done);
                  $display("   actual   x=%0d y=%0d addr=%h color=%h we=%b last=%b done=%b",
                           got.px, got.py, got.addr, got.color, got.we, got.last, got.done);
                  failures++;
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake or a missing pixel word ends the run here.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : run_phases
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = cor_pkg::MODE_STEP;
      req_ch.center_x  = '0;
      req_ch.center_y  = '0;
      req_ch.radius    = '0;
      req_ch.color     = '0;
      rsp_ch.ready     = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words on the reset surface size with no idling.
      // A step before any circle exists gets a blank word.
      push_word(make_step());
      // A zero radius completes in one step with eight copies of the center,
      // and the step after that is blank again.
      push_word(make_start(0, 0, 0, 32'h0000_0000));
      repeat (2) push_word(make_step());
      // Largest radius at the extreme corners: coordinates reach the ends of
      // their range and every point is clipped.
      push_word(make_start(4095, 4095, 4095, 32'hFFFF_FFFF));
      repeat (2) push_word(make_step());
      // A new start while a circle is still active replaces it.
      push_word(make_start(-4096, -4096, 4095, 32'hA5A5_A5A5));
      repeat (2) push_word(make_step());
      // A small circle fully on the surface, driven past its end.
      push_word(make_start(320, 240, 5, 32'h1234_5678));
      repeat (5) push_word(make_step());
      // Circles on the origin and on the far corner straddle the clip edges.
      push_word(make_start(0, 0, 3, 32'h0F0F_00FF));
      repeat (3) push_word(make_step());
      push_word(make_start(639, 479, 1, 32'h8000_0001));
      repeat (2) push_word(make_step());

      // Random phases, each with its own surface size and idling mix. The
      // sizes cover the largest side, a single pixel, register values past
      // saturation, a zero-sized surface and an arbitrary one.
      run_phase(4096, 4096, 0, 0, 15);
      run_phase(1, 1, 85, 0, 15);
      run_phase(8191, 5000, 0, 85, 15);
      run_phase(0, 0, 30, 30, 15);
      run_phase($urandom_range(1, 300), $urandom_range(1, 300), 30, 30, 15);

      wait_idle();
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
